// ===== hw/rtl/gsd_pkg.sv =====
// gsd_pkg: shared widths, register indexes, reset values and sequencer states
// for the gyro step detector. No dependencies; every other file of the block
// but gsd_div uses it through scoped names.
package gsd_pkg;

  // Field widths
  localparam int RATE_W = 16;
  localparam int TIME_W = 32;
  localparam int SQ_W   = 32;
  localparam int MAG_W  = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int IN_W   = 80;
  localparam int OUT_W  = 40;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_BAND_OFFSET = 2'd0;
  localparam logic [IDX_W-1:0] REG_STILL_LEVEL = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_GAP     = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPIKE_WIN   = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] BAND_OFFSET_RST = 16'd4710;
  localparam logic [CFG_W-1:0] STILL_LEVEL_RST = 16'd205;
  localparam logic [CFG_W-1:0] MIN_GAP_RST     = 16'd500;
  localparam logic [CFG_W-1:0] SPIKE_WIN_RST   = 16'd500;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_READ,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIV,
    ST_DECIDE
  } state_t;

endpackage

// ===== hw/rtl/gsd_sumsq.sv =====
// gsd_sumsq: bit-serial sum of squares of three signed rates, one multiplier
// bit per cycle. Depends on gsd_pkg.
module gsd_sumsq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [gsd_pkg::RATE_W-1:0] rate_x,
  input  logic signed [gsd_pkg::RATE_W-1:0] rate_y,
  input  logic signed [gsd_pkg::RATE_W-1:0] rate_z,
  output logic                              done,
  output logic [gsd_pkg::SQ_W-1:0]          sum_sq
);

  logic [gsd_pkg::RATE_W-1:0] mplier;
  logic [gsd_pkg::RATE_W-1:0] next_a;
  logic [gsd_pkg::RATE_W-1:0] next_b;
  logic [gsd_pkg::SQ_W-1:0]   mcand;
  logic [3:0]                 bitc;
  logic [1:0]                 axis;
  logic                       run;
  logic [gsd_pkg::RATE_W-1:0] abs_x, abs_y, abs_z;

  // Magnitudes of the rates; the most negative code maps to 32768
  assign abs_x = rate_x[gsd_pkg::RATE_W-1] ? gsd_pkg::RATE_W'(-rate_x) : rate_x;
  assign abs_y = rate_y[gsd_pkg::RATE_W-1] ? gsd_pkg::RATE_W'(-rate_y) : rate_y;
  assign abs_z = rate_z[gsd_pkg::RATE_W-1] ? gsd_pkg::RATE_W'(-rate_z) : rate_z;

  // Control: bit and axis counters
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      bitc <= '0;
      axis <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        bitc <= '0;
        axis <= '0;
      end else if (run) begin
        bitc <= bitc + 4'd1;
        if (bitc == 4'd15) begin
          if (axis == 2'd2) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            axis <= axis + 2'd1;
          end
        end
      end
    end
  end

  // Datapath: shift-and-add, next axes wait in a short shift line
  always_ff @(posedge clk) begin
    if (start) begin
      mplier <= abs_x;
      mcand  <= {{(gsd_pkg::SQ_W-gsd_pkg::RATE_W){1'b0}}, abs_x};
      next_a <= abs_y;
      next_b <= abs_z;
      sum_sq <= '0;
    end else if (run) begin
      if (mplier[0]) begin
        sum_sq <= sum_sq + mcand;
      end
      if (bitc == 4'd15) begin
        mplier <= next_a;
        mcand  <= {{(gsd_pkg::SQ_W-gsd_pkg::RATE_W){1'b0}}, next_a};
        next_a <= next_b;
      end else begin
        mplier <= mplier >> 1;
        mcand  <= mcand << 1;
      end
    end
  end

endmodule

// ===== hw/rtl/gsd_isqrt.sv =====
// gsd_isqrt: digit-by-digit integer square root, two radicand bits per
// cycle. Depends on gsd_pkg.
module gsd_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gsd_pkg::SQ_W-1:0]   radicand,
  output logic                       done,
  output logic [gsd_pkg::MAG_W-1:0]  root
);

  localparam int REM_W = gsd_pkg::MAG_W + 2;

  logic [gsd_pkg::SQ_W-1:0] n;
  logic [REM_W-1:0]         rem;
  logic [3:0]               cnt;
  logic                     run;
  logic [REM_W+1:0]         rem_sh;
  logic [REM_W+1:0]         trial;
  logic                     fits;

  // One root digit: bring down two bits, try 4*root+1
  always_comb begin
    rem_sh = {rem, n[gsd_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      n <= n << 2;
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[gsd_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[gsd_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/gsd_div.sv =====
// gsd_div: restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module gsd_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Shift in the next dividend bit and try the divisor
  always_comb begin
    rem_sh = {rem, quot[NUM_W-1]};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      dvs  <= den;
      rem  <= '0;
    end else if (run) begin
      if (fits) begin
        rem  <= DEN_W'(rem_sh - {1'b0, dvs});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= DEN_W'(rem_sh);
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/gyro_step_detector_top.sv =====
// gyro_step_detector_top: step detection from gyro magnitude against a band
// around a moving average. Uses gsd_pkg, gsd_sumsq, gsd_isqrt and gsd_div.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  rate_x, rate_y, rate_z, time_ms
//  m_*      out  m_tvalid/m_tready  step_found, step_total, paused, average_rate
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One sample at a time: the next word is accepted only once the result of the last
// one is committed to the output register, which is when the result word turns
// valid. Each sample passes through the bit-serial squaring, the root, the ring
// read and update and the divider before the decision is committed.
// Reset is synchronous and clears the window, arming, timers and step count.
// A result held in the output register does not block the next accept; the
// sequencer only waits before committing while that register is still full.
module gyro_step_detector_top #(
  parameter int WINDOW_LEN = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // s_tdata: rate_x[15:0], rate_y[31:16], rate_z[47:32], time_ms[79:48]
  input  logic [gsd_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // m_tdata: step_found[0], step_total[16:1], paused[17], average_rate[33:18], zeros
  output logic [gsd_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_we,
  input  logic [gsd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gsd_pkg::CFG_W-1:0]   cfg_data
);

  localparam int SUM_W  = gsd_pkg::MAG_W + $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TW     = gsd_pkg::TIME_W;
  localparam int MW     = gsd_pkg::MAG_W;

  gsd_pkg::state_t state, state_next;

  logic [gsd_pkg::CFG_W-1:0] band_offset, still_level, min_gap, spike_win;

  logic [TW-1:0]     t_ms;
  logic [MW-1:0]     mag;
  logic [MW-1:0]     old_mag;
  logic [MW-1:0]     ring [WINDOW_LEN];
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [SUM_W-1:0]  win_sum;
  logic [MW-1:0]     avg;
  logic              armed_high;
  logic [TW-1:0]     rise_time, step_time, pause_end;
  logic [MW-1:0]     step_counter;

  logic              res_found, res_paused;
  logic [MW-1:0]     res_total, res_avg;

  logic              s_accept;
  logic              sq_done, root_done, div_done;
  logic [gsd_pkg::SQ_W-1:0] sum_sq;
  logic [MW-1:0]     root;
  logic [SUM_W-1:0]  quot;
  logic              commit;
  logic              full;

  // Decision terms
  logic              above, below, in_pause, timing_ok;
  logic [TW-1:0]     rise_el, step_el;
  logic              armed_next, set_rise, found;
  logic [MW-1:0]     step_counter_next;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = (state == gsd_pkg::ST_IDLE);
  assign full     = (fill_count == CNT_W'(WINDOW_LEN));

  // Arithmetic units
  gsd_sumsq u_sumsq (
    .clk    (clk),
    .rst    (rst),
    .start  (s_accept),
    .rate_x (s_tdata[15:0]),
    .rate_y (s_tdata[31:16]),
    .rate_z (s_tdata[47:32]),
    .done   (sq_done),
    .sum_sq (sum_sq)
  );

  gsd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_done),
    .radicand (sum_sq),
    .done     (root_done),
    .root     (root)
  );

  gsd_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == gsd_pkg::ST_DIV_GO),
    .num   (win_sum),
    .den   (fill_count),
    .done  (div_done),
    .quot  (quot)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    commit     = 1'b0;
    case (state)
      gsd_pkg::ST_IDLE:   if (s_accept) state_next = gsd_pkg::ST_SQUARE;
      gsd_pkg::ST_SQUARE: if (sq_done) state_next = gsd_pkg::ST_ROOT;
      gsd_pkg::ST_ROOT:   if (root_done) state_next = gsd_pkg::ST_READ;
      gsd_pkg::ST_READ:   state_next = gsd_pkg::ST_UPDATE;
      gsd_pkg::ST_UPDATE: state_next = gsd_pkg::ST_DIV_GO;
      gsd_pkg::ST_DIV_GO: state_next = gsd_pkg::ST_DIV;
      gsd_pkg::ST_DIV:    if (div_done) state_next = gsd_pkg::ST_DECIDE;
      gsd_pkg::ST_DECIDE: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = gsd_pkg::ST_IDLE;
        end
      end
      default: state_next = gsd_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      band_offset <= gsd_pkg::BAND_OFFSET_RST;
      still_level <= gsd_pkg::STILL_LEVEL_RST;
      min_gap     <= gsd_pkg::MIN_GAP_RST;
      spike_win   <= gsd_pkg::SPIKE_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsd_pkg::REG_BAND_OFFSET: band_offset <= cfg_data;
        gsd_pkg::REG_STILL_LEVEL: still_level <= cfg_data;
        gsd_pkg::REG_MIN_GAP:     min_gap     <= cfg_data;
        gsd_pkg::REG_SPIKE_WIN:   spike_win   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture timestamp, magnitude and average
  always_ff @(posedge clk) begin
    if (s_accept) begin
      t_ms <= s_tdata[79:48];
    end
    if (root_done) begin
      mag <= root;
    end
    if (div_done) begin
      avg <= quot[MW-1:0];
    end
  end

  // Magnitude ring: read the entry about to be replaced, then overwrite it
  always_ff @(posedge clk) begin
    if (state == gsd_pkg::ST_READ) begin
      old_mag <= ring[write_slot];
    end
    if (state == gsd_pkg::ST_UPDATE) begin
      ring[write_slot] <= mag;
    end
  end

  // Window bookkeeping: slot, fill and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      win_sum    <= '0;
    end else if (state == gsd_pkg::ST_UPDATE) begin
      if (write_slot == SLOT_W'(WINDOW_LEN - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + SLOT_W'(1);
      end
      if (full) begin
        win_sum <= win_sum - SUM_W'(old_mag) + SUM_W'(mag);
      end else begin
        win_sum    <= win_sum + SUM_W'(mag);
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  // Thresholds, pause and step decision
  always_comb begin
    above     = {1'b0, mag} > ({1'b0, avg} + {1'b0, band_offset});
    below     = ({1'b0, mag} + {1'b0, band_offset}) < {1'b0, avg};
    in_pause  = t_ms < pause_end;
    rise_el   = t_ms - rise_time;
    step_el   = t_ms - step_time;
    timing_ok = (rise_el < {16'd0, spike_win}) && (step_el > {16'd0, min_gap});

    armed_next = armed_high;
    set_rise   = 1'b0;
    found      = 1'b0;
    if (!in_pause) begin
      if (above && !armed_high) begin
        armed_next = 1'b1;
        set_rise   = 1'b1;
      end else if (below && armed_high) begin
        found      = timing_ok;
        armed_next = 1'b0;
      end
      if (mag < still_level) begin
        armed_next = 1'b0;
      end
    end

    if (found && step_counter != {MW{1'b1}}) begin
      step_counter_next = step_counter + MW'(1);
    end else begin
      step_counter_next = step_counter;
    end
  end

  // Detector state, updated once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_high   <= 1'b0;
      rise_time    <= '0;
      step_time    <= '0;
      pause_end    <= '0;
      step_counter <= '0;
    end else if (commit) begin
      armed_high   <= armed_next;
      step_counter <= step_counter_next;
      if (set_rise) begin
        rise_time <= t_ms;
      end
      if (found) begin
        step_time <= t_ms;
        pause_end <= t_ms + {16'd0, min_gap};
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_found  <= found;
      res_total  <= step_counter_next;
      res_paused <= in_pause;
      res_avg    <= avg;
    end
  end

  assign m_tdata = {6'd0, res_avg, res_paused, res_total, res_found};

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(WINDOW_LEN - 1))
    else $error("write slot beyond window");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == gsd_pkg::ST_SQUARE))
    else $error("accepted word did not start squaring");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (step_counter == $past(step_counter) ||
              step_counter == MW'($past(step_counter) + MW'(1))))
    else $error("step count jumped");

  a_found_not_paused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res_found && res_paused))
    else $error("step reported inside pause");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for gyro_step_detector_top (stream in, stream out).
// Needs gsd_pkg and the detector RTL; carries its own step predictor.
module tb;

  localparam int WIN       = 15;
  localparam int MAG_MAX   = 56755;
  localparam int PHASE_LEN = 80;
  localparam int PHASES    = 8;
  localparam int LONG_HOLD = 900;
  localparam int TAIL      = 200;
  localparam int LIMIT     = 600000;

  // One gyro sample, laid out as on s_tdata (rate_x in the low bits)
  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] rate_z;
    logic [15:0] rate_y;
    logic [15:0] rate_x;
  } sample_t;

  typedef struct {
    bit        step_found;
    bit [15:0] step_total;
    bit        paused;
    bit [15:0] average_rate;
  } report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  // s_tdata: rate_x, rate_y, rate_z, time_ms
  logic [gsd_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // m_tdata: step_found, step_total, paused, average_rate, zero fill
  logic [gsd_pkg::OUT_W-1:0] m_tdata;
  logic                      cfg_we = 1'b0;
  logic [gsd_pkg::IDX_W-1:0] cfg_index = gsd_pkg::REG_BAND_OFFSET;
  logic [gsd_pkg::CFG_W-1:0] cfg_data = '0;

  gyro_step_detector_top #(.WINDOW_LEN(WIN)) dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  // Predictor copy of the registers and the detector state
  bit [15:0] cfg_band   = gsd_pkg::BAND_OFFSET_RST;
  bit [15:0] cfg_still  = gsd_pkg::STILL_LEVEL_RST;
  bit [15:0] cfg_gap    = gsd_pkg::MIN_GAP_RST;
  bit [15:0] cfg_window = gsd_pkg::SPIKE_WIN_RST;
  bit [15:0] mag_hist [WIN];
  int        hist_wr = 0;
  int        hist_fill = 0;
  bit        armed = 1'b0;
  bit [31:0] rise_ms = '0;
  bit [31:0] last_step_ms = '0;
  bit [31:0] hold_until = '0;
  bit [15:0] steps = '0;

  sample_t   sample_queue[$];
  report_t   pending_reports[$];
  bit [31:0] clock_ms = '0;
  int        n_queued = 0;
  int        n_checked = 0;
  int        n_accepted = 0;
  int        n_errors = 0;
  int        n_found = 0;
  int        n_paused = 0;
  int        n_settings = 0;
  int        hold_at = 32'h7fff_ffff;
  bit        no_idle = 1'b0;
  int        send_wait = 0;
  int        recv_wait = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit [15:0] root_floor(input bit [31:0] n);
    bit [15:0] r;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      r[b] = 1'b1;
      if (longint'(r) * r > n) r[b] = 1'b0;
    end
    return r;
  endfunction

  // Advance the detector state by one sample and return its report
  function automatic report_t track_sample(input sample_t s);
    longint    sq;
    bit [15:0] mag;
    bit [31:0] sum;
    bit [15:0] avg;
    longint    upper;
    longint    lower;
    bit [31:0] since_rise;
    bit [31:0] since_step;
    report_t   r;
    sq = longint'($signed(s.rate_x)) * $signed(s.rate_x)
       + longint'($signed(s.rate_y)) * $signed(s.rate_y)
       + longint'($signed(s.rate_z)) * $signed(s.rate_z);
    mag = root_floor(sq[31:0]);
    mag_hist[hist_wr] = mag;
    hist_wr = (hist_wr == WIN - 1) ? 0 : hist_wr + 1;
    if (hist_fill < WIN) hist_fill++;
    sum = '0;
    for (int i = 0; i < hist_fill; i++) sum += mag_hist[i];
    avg = sum / hist_fill;
    upper = longint'(avg) + longint'(cfg_band);
    lower = longint'(avg) - longint'(cfg_band);
    since_rise = s.time_ms - rise_ms;
    since_step = s.time_ms - last_step_ms;
    r.step_found = 1'b0;
    r.paused = s.time_ms < hold_until;
    // skip arming, step test and stillness clear while paused
    if (!r.paused) begin
      if (longint'(mag) > upper && !armed) begin
        armed = 1'b1;
        rise_ms = s.time_ms;
      end else if (longint'(mag) < lower && armed) begin
        if (since_rise < cfg_window && since_step > cfg_gap) begin
          if (steps != 16'hffff) steps++;
          r.step_found = 1'b1;
          last_step_ms = s.time_ms;
          hold_until = s.time_ms + cfg_gap;
        end
        armed = 1'b0;
      end
      if (mag < cfg_still) armed = 1'b0;
    end
    r.step_total = steps;
    r.average_rate = avg;
    if (r.step_found) n_found++;
    if (r.paused) n_paused++;
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endtask

  task automatic push_sample(input bit [15:0] x, input bit [15:0] y, input bit [15:0] z,
                             input bit [31:0] t);
    sample_t s;
    s.rate_x = x;
    s.rate_y = y;
    s.rate_z = z;
    s.time_ms = t;
    sample_queue.push_back(s);
    n_queued++;
  endtask

  // Queue a sample of roughly the given magnitude, dt ms after the last one
  task automatic add_mag(input int m, input int dt);
    int     part [3];
    longint rest;
    int     k;
    if (m > MAG_MAX) m = MAG_MAX;
    if (m < 0) m = 0;
    rest = longint'(m) * m;
    for (int i = 0; i < 3; i++) begin
      part[i] = root_floor(rest[31:0]);
      if (part[i] > 32767) part[i] = 32767;
      rest -= longint'(part[i]) * part[i];
      if ($urandom_range(0, 1)) part[i] = -part[i];
    end
    k = $urandom_range(0, 2);
    clock_ms += dt;
    push_sample(part[k], part[(k + 1) % 3], part[(k + 2) % 3], clock_ms);
  endtask

  // Random rates, time either stepped or thrown anywhere in the range
  task automatic add_noise();
    if ($urandom_range(0, 7) == 0) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, 1500);
    push_sample($urandom(), $urandom(), $urandom(), clock_ms);
  endtask

  // Baseline, rise above the band, fall below it, sometimes a quiet tail
  task automatic add_episode();
    int base;
    int peak;
    base = $urandom_range(1000, 30000);
    repeat ($urandom_range(0, 6))
      add_mag(base + $urandom_range(0, 2000) - 1000, $urandom_range(20, 300));
    peak = base + $urandom_range(0, 2 * cfg_band + 3000);
    add_mag(peak, $urandom_range(20, 300));
    if ($urandom_range(0, 3) == 0) add_mag(peak, $urandom_range(20, 200));
    add_mag($urandom_range(0, base / 2), $urandom_range(20, cfg_window + 200));
    if ($urandom_range(0, 2) == 0) add_mag($urandom_range(0, 1000), $urandom_range(20, 300));
  endtask

  task automatic write_reg(input logic [gsd_pkg::IDX_W-1:0] idx, input bit [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gsd_pkg::REG_BAND_OFFSET: cfg_band = val;
      gsd_pkg::REG_STILL_LEVEL: cfg_still = val;
      gsd_pkg::REG_MIN_GAP:     cfg_gap = val;
      gsd_pkg::REG_SPIKE_WIN:   cfg_window = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (n_checked != n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drain, load one register setting, then queue a batch of random samples
  task automatic run_phase(input int p);
    int first;
    wait_drained();
    case (p)
      1: begin
        write_reg(gsd_pkg::REG_BAND_OFFSET, gsd_pkg::BAND_OFFSET_RST);
        write_reg(gsd_pkg::REG_STILL_LEVEL, gsd_pkg::STILL_LEVEL_RST);
        write_reg(gsd_pkg::REG_MIN_GAP, gsd_pkg::MIN_GAP_RST);
        write_reg(gsd_pkg::REG_SPIKE_WIN, gsd_pkg::SPIKE_WIN_RST);
      end
      2: begin
        write_reg(gsd_pkg::REG_BAND_OFFSET, 16'd0);
        write_reg(gsd_pkg::REG_STILL_LEVEL, 16'd0);
        write_reg(gsd_pkg::REG_MIN_GAP, 16'd0);
        write_reg(gsd_pkg::REG_SPIKE_WIN, 16'hffff);
      end
      3: begin
        write_reg(gsd_pkg::REG_BAND_OFFSET, 16'hffff);
        write_reg(gsd_pkg::REG_STILL_LEVEL, 16'hffff);
        write_reg(gsd_pkg::REG_MIN_GAP, 16'hffff);
        write_reg(gsd_pkg::REG_SPIKE_WIN, 16'd0);
      end
      default: begin
        write_reg(gsd_pkg::REG_BAND_OFFSET, $urandom_range(500, 9000));
        write_reg(gsd_pkg::REG_STILL_LEVEL, $urandom_range(0, 3000));
        write_reg(gsd_pkg::REG_MIN_GAP, $urandom_range(50, 700));
        write_reg(gsd_pkg::REG_SPIKE_WIN, $urandom_range(150, 1200));
      end
    endcase
    n_settings++;
    no_idle = (p == 2 || p == 6);
    if (p == 4) hold_at = n_queued + 20;
    first = n_queued;
    while (n_queued - first < PHASE_LEN) begin
      if ($urandom_range(0, 3) == 0) add_noise();
      else add_episode();
    end
  endtask

  // Drive input words from the sample queue, with a random gap after each (none while no_idle is set)
  always @(posedge clk) begin
    report_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        r = track_sample(sample_t'(s_tdata));
        pending_reports.push_back(r);
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          s_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (sample_queue.size() > 0) begin
          s_tdata <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
          send_wait <= no_idle ? 0 : $urandom_range(0, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each output word against the oldest prediction; pace m_tready
  always @(posedge clk) begin
    report_t want;
    int      w;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, m_tdata);
          n_errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("step_found", want.step_found, m_tdata[0]);
          check_field("step_total", want.step_total, m_tdata[16:1]);
          check_field("paused", want.paused, m_tdata[17]);
          check_field("average_rate", want.average_rate, m_tdata[33:18]);
          n_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= (hold_left == 1);
      end else if (!hold_done && n_accepted >= hold_at) begin
        // hold off long enough for the block to back up into its input
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        w = no_idle ? 0 : $urandom_range(0, 5);
        recv_wait <= w;
        m_tready <= (w == 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_tready <= (recv_wait == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, n_queued - n_checked);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int p;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the rate fields, time starting at zero
    push_sample(16'h0000, 16'h0000, 16'h0000, 32'd0);
    push_sample(16'h7fff, 16'h7fff, 16'h7fff, 32'd100);
    push_sample(16'h8000, 16'h8000, 16'h8000, 32'd200);
    push_sample(16'h8000, 16'h7fff, 16'h0000, 32'd300);
    push_sample(16'h0000, 16'h0000, 16'h8000, 32'd400);
    clock_ms = 32'd400;
    // Clean step, then a sample inside the pause
    repeat (5) add_mag(12000, 100);
    add_mag(40000, 100);
    add_mag(1000, 100);
    add_mag(12000, 100);
    // Fall too late for the spike window
    add_mag(12000, 600);
    add_mag(40000, 100);
    add_mag(1000, 700);
    // Arm, then drop under the stillness level
    add_mag(40000, 100);
    add_mag(100, 100);
    // Step near the top of the time range: pause end wraps, no pause follows
    clock_ms = 32'hffff_fe80;
    add_mag(12000, 0);
    add_mag(40000, 100);
    add_mag(1000, 100);
    add_mag(12000, 100);

    for (p = 1; p <= PHASES; p++) run_phase(p);

    wait_drained();
    repeat (TAIL) @(posedge clk);
    $display("Checked %0d of %0d samples over %0d register settings plus reset values.",
             n_checked, n_queued, n_settings);
    $display("Predicted %0d steps and %0d paused samples; long output stall done: %0d.",
             n_found, n_paused, hold_done);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
